@@ hdl/i80af_pkg.sv @@
// Package of shared types, constants and functions for the 8080 ALU with flags.
`default_nettype none

package i80af_pkg;

   localparam int unsigned CmdWidth  = 4;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned WordWidth = 16;

   typedef enum logic [CmdWidth-1:0] {
      CMD_ADD        = 4'd0,
      CMD_ADC        = 4'd1,
      CMD_SUB        = 4'd2,
      CMD_SBB        = 4'd3,
      CMD_CMP        = 4'd4,
      CMD_AND        = 4'd5,
      CMD_OR         = 4'd6,
      CMD_XOR        = 4'd7,
      CMD_INC        = 4'd8,
      CMD_DEC        = 4'd9,
      CMD_DAD        = 4'd10,
      CMD_LOAD_ACC   = 4'd11,
      CMD_LOAD_HL    = 4'd12,
      CMD_LOAD_FLAGS = 4'd13
   } cmd_type;

   typedef struct packed {
      logic s;
      logic z;
      logic ac;
      logic p;
      logic cy;
   } flags_type;

   // Auxiliary carry tables indexed by {acc[3], operand[3], result[3]}.
   localparam logic [7:0] AcAddTab = 8'hD4;
   localparam logic [7:0] AcSubTab = 8'h8E;

   function automatic flags_type szp_flags(input logic [ByteWidth-1:0] v,
                                           input logic ac, input logic cy);
      flags_type f;
      f.s  = v[ByteWidth-1];
      f.z  = (v == '0);
      f.p  = ~^v;
      f.ac = ac;
      f.cy = cy;
      return f;
   endfunction

   function automatic logic [ByteWidth-1:0] pack_flags(input flags_type f);
      return {f.s, f.z, 1'b0, f.ac, 1'b0, f.p, 1'b1, f.cy};
   endfunction

endpackage

`default_nettype wire

@@ hdl/i80af_req_if.sv @@
// Request channel interface carrying one command word to the ALU.
`default_nettype none

interface i80af_req_if;
   logic                                valid;
   logic                                ready;
   logic [i80af_pkg::CmdWidth-1:0]      cmd;
   logic [i80af_pkg::ByteWidth-1:0]     operand_byte;
   logic [i80af_pkg::WordWidth-1:0]     operand_word;

   modport source (output valid, output cmd, output operand_byte, output operand_word,
                   input ready);
   modport sink (input valid, input cmd, input operand_byte, input operand_word,
                 output ready);
endinterface

`default_nettype wire

@@ hdl/i80af_rsp_if.sv @@
// Response channel interface carrying one result word from the ALU.
`default_nettype none

interface i80af_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [i80af_pkg::ByteWidth-1:0]     acc_out;
   logic [i80af_pkg::WordWidth-1:0]     hl_out;
   logic [i80af_pkg::ByteWidth-1:0]     step_value;
   logic [i80af_pkg::ByteWidth-1:0]     flag_byte;

   modport source (output valid, output acc_out, output hl_out, output step_value,
                   output flag_byte, input ready);
   modport sink (input valid, input acc_out, input hl_out, input step_value,
                 input flag_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/i8080_alu_flags.sv @@
// Top level of the 8080 ALU: accumulator, HL pair, flags and result register.
// A result word appears in the cycle after its request word is accepted.
// Throughput: one word per cycle; the ALU and flag logic is a single pass into
// the state and result registers, and a request is taken whenever the result
// register is empty or is being drained in the same cycle.
// Reset clears the accumulator, HL, all flags and the result valid bit.
`default_nettype none

module i8080_alu_flags (
   input  logic        clock,
   input  logic        reset,
   i80af_req_if.sink   req_chan,
   i80af_rsp_if.source rsp_chan
);

   logic [i80af_pkg::ByteWidth-1:0]  acc_ff, acc_in;
   logic [i80af_pkg::WordWidth-1:0]  hl_ff, hl_in;
   i80af_pkg::flags_type             flags_ff, flags_in;
   logic [i80af_pkg::ByteWidth-1:0]  step_in;

   logic                             rsp_valid_ff;
   logic [i80af_pkg::ByteWidth-1:0]  acc_out_ff;
   logic [i80af_pkg::WordWidth-1:0]  hl_out_ff;
   logic [i80af_pkg::ByteWidth-1:0]  step_ff;
   logic [i80af_pkg::ByteWidth-1:0]  flag_byte_ff;

   logic                             accept;
   i80af_pkg::cmd_type               cmd;
   logic [i80af_pkg::ByteWidth-1:0]  opb;
   logic                             is_sub;
   logic                             cin;
   logic [i80af_pkg::ByteWidth:0]    sum9;
   logic [i80af_pkg::ByteWidth:0]    diff9;
   logic [i80af_pkg::ByteWidth:0]    r9;
   logic [2:0]                       ac_idx;
   logic                             ac_arith;
   logic [i80af_pkg::WordWidth:0]    dad17;
   logic [i80af_pkg::ByteWidth-1:0]  logic_res;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign cmd = i80af_pkg::cmd_type'(req_chan.cmd);
   assign opb = req_chan.operand_byte;

   always_comb begin
      is_sub = (cmd == i80af_pkg::CMD_SUB) || (cmd == i80af_pkg::CMD_SBB) ||
               (cmd == i80af_pkg::CMD_CMP);
      cin = ((cmd == i80af_pkg::CMD_ADC) || (cmd == i80af_pkg::CMD_SBB)) ? flags_ff.cy : 1'b0;
      sum9 = {1'b0, acc_ff} + {1'b0, opb} + {{i80af_pkg::ByteWidth{1'b0}}, cin};
      diff9 = {1'b0, acc_ff} - {1'b0, opb} - {{i80af_pkg::ByteWidth{1'b0}}, cin};
      r9 = is_sub ? diff9 : sum9;
      ac_idx = {acc_ff[3], opb[3], r9[3]};
      ac_arith = is_sub ? ~i80af_pkg::AcSubTab[ac_idx] : i80af_pkg::AcAddTab[ac_idx];
      dad17 = {1'b0, hl_ff} + {1'b0, req_chan.operand_word};

      acc_in = acc_ff;
      hl_in = hl_ff;
      flags_in = flags_ff;
      step_in = '0;
      logic_res = acc_ff;

      case (cmd)
         i80af_pkg::CMD_ADD, i80af_pkg::CMD_ADC, i80af_pkg::CMD_SUB, i80af_pkg::CMD_SBB: begin
            acc_in = r9[i80af_pkg::ByteWidth-1:0];
            flags_in = i80af_pkg::szp_flags(r9[i80af_pkg::ByteWidth-1:0], ac_arith,
                                            r9[i80af_pkg::ByteWidth]);
         end
         i80af_pkg::CMD_CMP: begin
            flags_in = i80af_pkg::szp_flags(r9[i80af_pkg::ByteWidth-1:0], ac_arith,
                                            r9[i80af_pkg::ByteWidth]);
         end
         i80af_pkg::CMD_AND, i80af_pkg::CMD_OR, i80af_pkg::CMD_XOR: begin
            if (cmd == i80af_pkg::CMD_AND) begin
               logic_res = acc_ff & opb;
            end else if (cmd == i80af_pkg::CMD_OR) begin
               logic_res = acc_ff | opb;
            end else begin
               logic_res = acc_ff ^ opb;
            end
            acc_in = logic_res;
            flags_in = i80af_pkg::szp_flags(logic_res, 1'b0, 1'b0);
         end
         i80af_pkg::CMD_INC: begin
            step_in = opb + 8'd1;
            flags_in = i80af_pkg::szp_flags(step_in, step_in[3:0] == 4'h0, flags_ff.cy);
         end
         i80af_pkg::CMD_DEC: begin
            step_in = opb - 8'd1;
            flags_in = i80af_pkg::szp_flags(step_in, step_in[3:0] != 4'hF, flags_ff.cy);
         end
         i80af_pkg::CMD_DAD: begin
            hl_in = dad17[i80af_pkg::WordWidth-1:0];
            flags_in.cy = dad17[i80af_pkg::WordWidth];
         end
         i80af_pkg::CMD_LOAD_ACC: begin
            acc_in = opb;
         end
         i80af_pkg::CMD_LOAD_HL: begin
            hl_in = req_chan.operand_word;
         end
         i80af_pkg::CMD_LOAD_FLAGS: begin
            flags_in.s  = opb[7];
            flags_in.z  = opb[6];
            flags_in.ac = opb[4];
            flags_in.p  = opb[2];
            flags_in.cy = opb[0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         hl_ff <= '0;
         flags_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            acc_ff <= acc_in;
            hl_ff <= hl_in;
            flags_ff <= flags_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         acc_out_ff <= acc_in;
         hl_out_ff <= hl_in;
         step_ff <= step_in;
         flag_byte_ff <= i80af_pkg::pack_flags(flags_in);
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.acc_out = acc_out_ff;
   assign rsp_chan.hl_out = hl_out_ff;
   assign rsp_chan.step_value = step_ff;
   assign rsp_chan.flag_byte = flag_byte_ff;

endmodule

`default_nettype wire
